// ===== rtl/tpa_pkg.sv =====
package tpa_pkg;

  // Coordinate width the datapath is sized for.
  localparam int unsigned CW = 24;
  // Edge vector component width.
  localparam int unsigned DW = CW + 1;
  // Width of the product of an a-edge and a b-edge component.
  localparam int unsigned PW = 2 * DW;
  // Cross product component width.
  localparam int unsigned CRW = PW + 1;
  // Dot product width.
  localparam int unsigned DOTW = PW + 2;
  // Magnitude width of one cross component.
  localparam int unsigned MW = PW;
  // Half widths used to split a magnitude for squaring.
  localparam int unsigned HW = MW / 2;
  // Width of the squared norm and of the square root working registers.
  localparam int unsigned SQW = 106;
  // Number of result bits the square root resolves.
  localparam int unsigned ROOT_BITS = 53;
  // Width of the arctangent operands before rotation.
  localparam int unsigned NW = 51;
  // Width of the rotation x and y registers.
  localparam int unsigned XW = 56;
  // Width of the angle accumulator.
  localparam int unsigned ZW = 34;

  // Angle scale: pi is 2^31.
  localparam logic [31:0] PI_SCALED = 32'h8000_0000;
  localparam logic [31:0] HALF_PI_SCALED = 32'h4000_0000;

  typedef logic signed [CW-1:0] coord_t;

  // Special cases of the angle, carried alongside the arctangent operands.
  typedef struct packed {
    logic m_zero;
    logic d_zero;
    logic d_neg;
  } tpa_flags_t;

  // atan(2^-i) with pi = 2^31.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0: val = 32'h20000000;
      5'd1: val = 32'h12E4051E;
      5'd2: val = 32'h09FB385B;
      5'd3: val = 32'h051111D4;
      5'd4: val = 32'h028B0D43;
      5'd5: val = 32'h0145D7E1;
      5'd6: val = 32'h00A2F61E;
      5'd7: val = 32'h00517C55;
      5'd8: val = 32'h0028BE53;
      5'd9: val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/tpa_vec.sv =====
module tpa_vec import tpa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  coord_t                 a_x_i,
  input  coord_t                 a_y_i,
  input  coord_t                 a_z_i,
  input  coord_t                 p_x_i,
  input  coord_t                 p_y_i,
  input  coord_t                 p_z_i,
  input  coord_t                 b_x_i,
  input  coord_t                 b_y_i,
  input  coord_t                 b_z_i,
  output logic                   valid_o,
  output logic [SQW-1:0]         norm_sq_o,
  output logic signed [DOTW-1:0] dot_o
);

  logic [6:0] v_q;

  logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [PW-1:0] prod_q [9];
  logic signed [CRW-1:0] cross_q [3];
  logic [MW-1:0] mag_q [3];
  logic [PW-1:0] hh_q [3];
  logic [PW-1:0] hl_q [3];
  logic [PW-1:0] ll_q [3];
  logic [SQW-1:0] sq_q [3];
  logic [SQW-1:0] norm_q;
  logic signed [DOTW-1:0] dot3_q, dot4_q, dot5_q, dot6_q, dot7_q;

  // Valid bits shift along with the data whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // Edge vectors from the apex, then the nine products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= DW'(a_x_i) - DW'(p_x_i);
      ay_q <= DW'(a_y_i) - DW'(p_y_i);
      az_q <= DW'(a_z_i) - DW'(p_z_i);
      bx_q <= DW'(b_x_i) - DW'(p_x_i);
      by_q <= DW'(b_y_i) - DW'(p_y_i);
      bz_q <= DW'(b_z_i) - DW'(p_z_i);
      prod_q[0] <= PW'(ay_q) * PW'(bz_q);
      prod_q[1] <= PW'(az_q) * PW'(by_q);
      prod_q[2] <= PW'(az_q) * PW'(bx_q);
      prod_q[3] <= PW'(ax_q) * PW'(bz_q);
      prod_q[4] <= PW'(ax_q) * PW'(by_q);
      prod_q[5] <= PW'(ay_q) * PW'(bx_q);
      prod_q[6] <= PW'(ax_q) * PW'(bx_q);
      prod_q[7] <= PW'(ay_q) * PW'(by_q);
      prod_q[8] <= PW'(az_q) * PW'(bz_q);
    end
  end

  // Cross and dot products, then the squared norm of the cross product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cross_q[0] <= CRW'(prod_q[0]) - CRW'(prod_q[1]);
      cross_q[1] <= CRW'(prod_q[2]) - CRW'(prod_q[3]);
      cross_q[2] <= CRW'(prod_q[4]) - CRW'(prod_q[5]);
      dot3_q <= DOTW'(prod_q[6]) + DOTW'(prod_q[7]) + DOTW'(prod_q[8]);
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= cross_q[k][CRW-1] ? MW'(-cross_q[k]) : MW'(cross_q[k]);
        hh_q[k] <= PW'(mag_q[k][MW-1:HW]) * PW'(mag_q[k][MW-1:HW]);
        hl_q[k] <= PW'(mag_q[k][MW-1:HW]) * PW'(mag_q[k][HW-1:0]);
        ll_q[k] <= PW'(mag_q[k][HW-1:0]) * PW'(mag_q[k][HW-1:0]);
        sq_q[k] <= (SQW'(hh_q[k]) << (2 * HW)) + (SQW'(hl_q[k]) << (HW + 1))
                   + SQW'(ll_q[k]);
      end
      norm_q <= sq_q[0] + sq_q[1] + sq_q[2];
      dot4_q <= dot3_q;
      dot5_q <= dot4_q;
      dot6_q <= dot5_q;
      dot7_q <= dot6_q;
    end
  end

  assign valid_o   = v_q[6];
  assign norm_sq_o = norm_q;
  assign dot_o     = dot7_q;

endmodule

// ===== rtl/tpa_isqrt.sv =====
module tpa_isqrt import tpa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SQW-1:0]         norm_sq_i,
  input  logic signed [DOTW-1:0] dot_i,
  output logic                   valid_o,
  output logic [NW-1:0]          root_o,
  output logic signed [DOTW-1:0] dot_o
);

  logic [SQW-1:0] op_q [ROOT_BITS];
  logic [SQW-1:0] res_q [ROOT_BITS];
  logic signed [DOTW-1:0] dot_q [ROOT_BITS];
  logic [ROOT_BITS-1:0] v_q;

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_bit
    localparam int unsigned B = ROOT_BITS - 1 - k;
    localparam logic [SQW-1:0] ONE = SQW'(1) << (2 * B);

    logic [SQW-1:0] op_in, res_in, trial, op_d, res_d;
    logic signed [DOTW-1:0] dot_in;
    logic v_in;

    if (k == 0) begin : g_first
      assign op_in  = norm_sq_i;
      assign res_in = '0;
      assign dot_in = dot_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign op_in  = op_q[k-1];
      assign res_in = res_q[k-1];
      assign dot_in = dot_q[k-1];
      assign v_in   = v_q[k-1];
    end

    // Keep the trial bit when its square still fits in the remainder.
    assign trial = res_in + ONE;
    always_comb begin
      if (op_in >= trial) begin
        op_d  = op_in - trial;
        res_d = (res_in >> 1) + ONE;
      end else begin
        op_d  = op_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        op_q[k]  <= op_d;
        res_q[k] <= res_d;
        dot_q[k] <= dot_in;
      end
    end
  end

  assign valid_o = v_q[ROOT_BITS-1];
  assign root_o  = res_q[ROOT_BITS-1][NW-1:0];
  assign dot_o   = dot_q[ROOT_BITS-1];

endmodule

// ===== rtl/tpa_cordic.sv =====
module tpa_cordic import tpa_pkg::*; #(
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [NW-1:0]          root_i,
  input  logic signed [DOTW-1:0] dot_i,
  output logic                   valid_o,
  output logic [ANGLE_BITS-1:0]  angle_o
);

  localparam int unsigned NS = (ROTATION_STEPS > 32) ? 32 : ROTATION_STEPS;
  localparam int unsigned SH = 32 - ANGLE_BITS;

  // Shift both operands left by s when the top s bits of both are clear.
  function automatic logic [2*NW-1:0] norm_step(input logic [NW-1:0] x,
                                                input logic [NW-1:0] y,
                                                input int unsigned s);
    logic [NW-1:0] both;
    logic [2*NW-1:0] r;
    both = x | y;
    if ((both >> (NW - s)) == '0) begin
      r = {x << s, y << s};
    end else begin
      r = {x, y};
    end
    return r;
  endfunction

  logic [3:0] vn_q;
  tpa_flags_t fl_q [4];
  logic [NW-1:0] nx_q [4];
  logic [NW-1:0] ny_q [4];
  logic [2*NW-1:0] s1, s2, s3, s4, s5, s6;

  logic [NS-1:0] vr_q;
  tpa_flags_t rfl_q [NS];
  logic signed [XW-1:0] rx_q [NS];
  logic signed [XW-1:0] ry_q [NS];
  logic signed [ZW-1:0] rz_q [NS];

  logic vp_q, vo_q;
  logic [31:0] zc, phi_d, phi_q;
  logic [32:0] rnd;
  logic [ANGLE_BITS-1:0] angle_q;

  // Operand setup, then normalization in three stages of two shifts each.
  assign s1 = norm_step(nx_q[0], ny_q[0], 32);
  assign s2 = norm_step(s1[2*NW-1:NW], s1[NW-1:0], 16);
  assign s3 = norm_step(nx_q[1], ny_q[1], 8);
  assign s4 = norm_step(s3[2*NW-1:NW], s3[NW-1:0], 4);
  assign s5 = norm_step(nx_q[2], ny_q[2], 2);
  assign s6 = norm_step(s5[2*NW-1:NW], s5[NW-1:0], 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= '0;
    end else if (en_i) begin
      vn_q <= {vn_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q[0].m_zero <= (root_i == '0);
      fl_q[0].d_zero <= (dot_i == '0);
      fl_q[0].d_neg  <= dot_i[DOTW-1];
      nx_q[0] <= dot_i[DOTW-1] ? NW'(-dot_i) : NW'(dot_i);
      ny_q[0] <= root_i;
      fl_q[1] <= fl_q[0];
      {nx_q[1], ny_q[1]} <= s2;
      fl_q[2] <= fl_q[1];
      {nx_q[2], ny_q[2]} <= s4;
      fl_q[3] <= fl_q[2];
      {nx_q[3], ny_q[3]} <= s6;
    end
  end

  // One micro-rotation per stage; a stage whose y is zero passes through.
  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [XW-1:0] x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d;
    logic [ZW-1:0] step;
    tpa_flags_t f_in;
    logic v_in;

    if (i == 0) begin : g_first
      assign x_in = XW'(nx_q[3]);
      assign y_in = XW'(ny_q[3]);
      assign z_in = '0;
      assign f_in = fl_q[3];
      assign v_in = vn_q[3];
    end else begin : g_next
      assign x_in = rx_q[i-1];
      assign y_in = ry_q[i-1];
      assign z_in = rz_q[i-1];
      assign f_in = rfl_q[i-1];
      assign v_in = vr_q[i-1];
    end

    assign step = ZW'(atan_entry(5'(i)));

    always_comb begin
      if (y_in == '0) begin
        x_d = x_in;
        y_d = y_in;
        z_d = z_in;
      end else if (!y_in[XW-1]) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + signed'(step);
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - signed'(step);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vr_q[i] <= 1'b0;
      end else if (en_i) begin
        vr_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[i]  <= x_d;
        ry_q[i]  <= y_d;
        rz_q[i]  <= z_d;
        rfl_q[i] <= f_in;
      end
    end
  end

  // Clamp to the first quadrant, fold in the sign of the dot product and handle a zero cross or dot product.
  always_comb begin
    if (rz_q[NS-1][ZW-1]) begin
      zc = '0;
    end else if (rz_q[NS-1] > ZW'(HALF_PI_SCALED)) begin
      zc = HALF_PI_SCALED;
    end else begin
      zc = rz_q[NS-1][31:0];
    end
    if (rfl_q[NS-1].m_zero) begin
      phi_d = rfl_q[NS-1].d_neg ? PI_SCALED : '0;
    end else if (rfl_q[NS-1].d_zero) begin
      phi_d = HALF_PI_SCALED;
    end else if (rfl_q[NS-1].d_neg) begin
      phi_d = PI_SCALED - zc;
    end else begin
      phi_d = zc;
    end
  end

  // Round half up to the output scale.
  assign rnd = ({1'b0, phi_q} + (33'(1) << (SH - 1))) >> SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= vr_q[NS-1];
      vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_q   <= phi_d;
      angle_q <= rnd[ANGLE_BITS-1:0];
    end
  end

  assign valid_o = vo_q;
  assign angle_o = angle_q;

endmodule

// ===== rtl/three_point_angle_unit.sv =====
// Channel  Direction  Handshake                  Beat contents
// in       input      in_valid_i / in_ready_o    end_a, apex and end_b coordinates
// out      output     out_valid_o / out_ready_i  angle at the apex, pi = 2^(ANGLE_BITS-1)
//
// One beat is accepted every cycle while the output is not stalled; each result passes
// through 7 vector stages, 53 square root stages, 4 setup and normalize stages,
// the rotation stages and 2 rounding stages.
// Reset clears only the valid bits of the pipeline.
// A stalled output beat freezes the whole pipeline, so nothing is lost or repeated.
module three_point_angle_unit import tpa_pkg::*; #(
  parameter int unsigned COORD_BITS     = 24,
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] end_a_x_i,
  input  logic [COORD_BITS-1:0] end_a_y_i,
  input  logic [COORD_BITS-1:0] end_a_z_i,
  input  logic [COORD_BITS-1:0] apex_x_i,
  input  logic [COORD_BITS-1:0] apex_y_i,
  input  logic [COORD_BITS-1:0] apex_z_i,
  input  logic [COORD_BITS-1:0] end_b_x_i,
  input  logic [COORD_BITS-1:0] end_b_y_i,
  input  logic [COORD_BITS-1:0] end_b_z_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ANGLE_BITS-1:0] angle_o
);

  localparam int unsigned CWL = (COORD_BITS > CW) ? CW : COORD_BITS;

  logic en;
  logic vec_valid, sq_valid;
  logic [SQW-1:0] norm_sq;
  logic signed [DOTW-1:0] vec_dot, sq_dot;
  logic [NW-1:0] root;

  // The pipeline advances unless the output beat is waiting.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  tpa_vec u_vec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .a_x_i     (coord_t'(signed'(end_a_x_i[CWL-1:0]))),
    .a_y_i     (coord_t'(signed'(end_a_y_i[CWL-1:0]))),
    .a_z_i     (coord_t'(signed'(end_a_z_i[CWL-1:0]))),
    .p_x_i     (coord_t'(signed'(apex_x_i[CWL-1:0]))),
    .p_y_i     (coord_t'(signed'(apex_y_i[CWL-1:0]))),
    .p_z_i     (coord_t'(signed'(apex_z_i[CWL-1:0]))),
    .b_x_i     (coord_t'(signed'(end_b_x_i[CWL-1:0]))),
    .b_y_i     (coord_t'(signed'(end_b_y_i[CWL-1:0]))),
    .b_z_i     (coord_t'(signed'(end_b_z_i[CWL-1:0]))),
    .valid_o   (vec_valid),
    .norm_sq_o (norm_sq),
    .dot_o     (vec_dot)
  );

  tpa_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (vec_valid),
    .norm_sq_i (norm_sq),
    .dot_i     (vec_dot),
    .valid_o   (sq_valid),
    .root_o    (root),
    .dot_o     (sq_dot)
  );

  tpa_cordic #(
    .ANGLE_BITS     (ANGLE_BITS),
    .ROTATION_STEPS (ROTATION_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (root),
    .dot_i   (sq_dot),
    .valid_o (out_valid_o),
    .angle_o (angle_o)
  );

endmodule

// ===== tb/tb_three_point_angle_unit.sv =====
`timescale 1ns / 100ps

module tb_three_point_angle_unit;
  import tpa_pkg::*;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned ROTATION_STEPS = 16;
  localparam int unsigned LATENCY = 66 + ROTATION_STEPS;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned EXP_DEPTH = 2048;

  // Idle phases of the sender and the receiver.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [COORD_BITS-1:0] end_a_x_i, end_a_y_i, end_a_z_i;
  logic [COORD_BITS-1:0] apex_x_i, apex_y_i, apex_z_i;
  logic [COORD_BITS-1:0] end_b_x_i, end_b_y_i, end_b_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [ANGLE_BITS-1:0] angle_o;

  // Expected angles in order, written at acceptance and read at each output beat.
  logic [15:0] expected_angles [EXP_DEPTH];
  logic [10:0] exp_wr;
  logic [10:0] exp_rd;
  int unsigned error_count;
  longint unsigned cycle_count;
  idle_mode_e idle_mode;
  int unsigned hold_off_cycles;

  three_point_angle_unit #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS),
    .ROTATION_STEPS(ROTATION_STEPS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .end_a_x_i(end_a_x_i),
    .end_a_y_i(end_a_y_i),
    .end_a_z_i(end_a_z_i),
    .apex_x_i(apex_x_i),
    .apex_y_i(apex_y_i),
    .apex_z_i(apex_z_i),
    .end_b_x_i(end_b_x_i),
    .end_b_y_i(end_b_y_i),
    .end_b_z_i(end_b_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .angle_o(angle_o)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shift_floor(input longint v, input int unsigned s);
    return v >>> s;
  endfunction

  // Floor of the square root of the squared cross product length.
  function automatic longint unsigned cross_length(input longint cx, input longint cy,
                                                   input longint cz);
    logic signed [127:0] wx, wy, wz;
    logic [127:0] norm_sq;
    logic [127:0] trial_sq;
    logic [63:0] root;
    logic [63:0] trial;
    wx = 128'(cx);
    wy = 128'(cy);
    wz = 128'(cz);
    norm_sq = wx * wx + wy * wy + wz * wz;
    root = '0;
    for (int b = 52; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      trial_sq = 128'(trial) * 128'(trial);
      if (trial_sq <= norm_sq) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Vectoring arctangent in the first quadrant, pi = 2^31.
  function automatic longint quadrant_angle(input longint x_in, input longint y_in);
    longint x, y, nx, ny, z;
    x = x_in;
    y = y_in;
    z = 0;
    while ((x > y ? x : y) < (64'sd1 <<< 50)) begin
      x = x <<< 1;
      y = y <<< 1;
    end
    for (int i = 0; i < ROTATION_STEPS && i < 32; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + shift_floor(y, i);
        ny = y - shift_floor(x, i);
        z = z + longint'(atan_entry(5'(i)));
      end else begin
        nx = x - shift_floor(y, i);
        ny = y + shift_floor(x, i);
        z = z - longint'(atan_entry(5'(i)));
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_SCALED)) z = longint'(HALF_PI_SCALED);
    return z;
  endfunction

  // Angle at the apex in units of pi/32768.
  function automatic logic [15:0] apex_angle(input coord_t pts[9]);
    longint ax, ay, az, bx, by, bz, cx, cy, cz, dot, len, phi;
    logic [63:0] rounded;
    ax = longint'(pts[0]) - longint'(pts[3]);
    ay = longint'(pts[1]) - longint'(pts[4]);
    az = longint'(pts[2]) - longint'(pts[5]);
    bx = longint'(pts[6]) - longint'(pts[3]);
    by = longint'(pts[7]) - longint'(pts[4]);
    bz = longint'(pts[8]) - longint'(pts[5]);
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    dot = ax * bx + ay * by + az * bz;
    len = longint'(cross_length(cx, cy, cz));
    if (len == 0) begin
      phi = dot < 0 ? longint'(PI_SCALED) : 0;
    end else if (dot == 0) begin
      phi = longint'(HALF_PI_SCALED);
    end else if (dot > 0) begin
      phi = quadrant_angle(dot, len);
    end else begin
      phi = longint'(PI_SCALED) - quadrant_angle(-dot, len);
    end
    rounded = (64'(phi) + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    return rounded[15:0];
  endfunction

  // Sends one beat of three points, idling beforehand as the phase asks.
  task automatic send_points(input coord_t pts[9]);
    if ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) && $urandom_range(99) < 81) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 81);
    end
    in_valid_i <= 1'b1;
    end_a_x_i <= pts[0];
    end_a_y_i <= pts[1];
    end_a_z_i <= pts[2];
    apex_x_i <= pts[3];
    apex_y_i <= pts[4];
    apex_z_i <= pts[5];
    end_b_x_i <= pts[6];
    end_b_y_i <= pts[7];
    end_b_z_i <= pts[8];
    do @(posedge clk_i); while (!in_ready_o);
    expected_angles[exp_wr] = apex_angle(pts);
    exp_wr = exp_wr + 11'd1;
  endtask

  // Lowers valid once a run of beats is done.
  task automatic go_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected angle has come back.
  task automatic drain_results();
    while (exp_wr != exp_rd) @(posedge clk_i);
  endtask

  function automatic coord_t random_coord();
    case ($urandom_range(5))
      0: return coord_t'(24'h800000 + $urandom_range(15));
      1: return coord_t'(24'h7FFFFF - $urandom_range(15));
      2: return coord_t'($urandom_range(64) - 32);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Random triangle; some have a repeated or collinear point.
  task automatic send_random_triangle();
    coord_t pts[9];
    int unsigned shape;
    int signed k;
    for (int i = 0; i < 9; i++) pts[i] = random_coord();
    shape = $urandom_range(9);
    if (shape == 0) begin
      for (int i = 0; i < 3; i++) pts[i] = pts[i + 3];
    end else if (shape == 1) begin
      // End point B on the line through the apex and A, either direction.
      k = $urandom_range(1) ? 1 : -1;
      for (int i = 0; i < 3; i++) begin
        pts[i] = coord_t'($urandom_range(2000) - 1000);
        pts[i + 3] = coord_t'($urandom_range(2000) - 1000);
        pts[i + 6] = coord_t'(pts[i + 3] + k * (pts[i] - pts[i + 3]));
      end
    end else if (shape == 2) begin
      // Small coordinates give many near and exact right angles.
      for (int i = 0; i < 9; i++) pts[i] = coord_t'($urandom_range(6) - 3);
    end
    send_points(pts);
  endtask

  function automatic void set_points(output coord_t pts[9], input int a[9]);
    for (int i = 0; i < 9; i++) pts[i] = coord_t'(a[i]);
  endfunction

  // Extremes, degenerate edges, right angles and straight angles.
  task automatic test_directed();
    coord_t pts[9];
    int cases[20][9] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{5, 0, 0, 5, 0, 0, 9, 3, 1},
      '{5, 7, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 1, 0},
      '{0, 0, 1, 0, 0, 0, 1, 0, 0},
      '{1, 0, 0, 0, 0, 0, 2, 0, 0},
      '{1, 0, 0, 0, 0, 0, -3, 0, 0},
      '{1, 0, 0, 0, 0, 0, 1, 1, 0},
      '{1, 0, 0, 0, 0, 0, -1, 1, 0},
      '{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
        8388607, 8388607, 8388607},
      '{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
        8388607, -8388608, 8388607},
      '{-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
        8388607, 8388607, -8388608},
      '{8388607, -8388608, 0, -8388608, 8388607, 0, -8388608, -8388608, 0},
      '{8388607, 0, 0, -8388608, 0, 0, -8388608, 8388607, 0},
      '{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
        8388607, -8388608, -8388608},
      '{1000000, 1, 0, 0, 0, 0, 1000000, 0, 0},
      '{1000000, 1, 0, 0, 0, 0, -1000000, 0, 0},
      '{-1, -1, -1, 0, 0, 0, 1, 1, 1},
      '{3, 4, 0, 0, 0, 0, 4, -3, 0},
      '{-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
        8388607, 8388607, 8388607}
    };
    for (int n = 0; n < 20; n++) begin
      set_points(pts, cases[n]);
      send_points(pts);
    end
    go_quiet();
  endtask

  task automatic test_random_phase(input idle_mode_e mode, input int unsigned beats);
    idle_mode = mode;
    repeat (beats) send_random_triangle();
    go_quiet();
  endtask

  // Receiver holds off long while the sender keeps offering beats.
  task automatic test_back_pressure();
    idle_mode = IDLE_NONE;
    hold_off_cycles = 300;
    repeat (150) send_random_triangle();
    go_quiet();
  endtask

  // Sender pauses until the pipeline has fully drained, then resumes.
  task automatic test_drain_pause();
    idle_mode = IDLE_NONE;
    repeat (40) send_random_triangle();
    go_quiet();
    drain_results();
    repeat (40) send_random_triangle();
    go_quiet();
  endtask

  // Receiver ready, with random stalls and a counted long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
      out_ready_i <= ($urandom_range(99) >= 81);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compares each accepted angle with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_rd == exp_wr) begin
        $display("%0t: unexpected angle beat, actual %0d", $time, angle_o);
        error_count++;
      end else begin
        if (angle_o !== expected_angles[exp_rd]) begin
          $display("%0t: angle mismatch, expected %0d, actual %0d",
                   $time, expected_angles[exp_rd], angle_o);
          error_count++;
        end
        exp_rd = exp_rd + 11'd1;
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {end_a_x_i, end_a_y_i, end_a_z_i} = '0;
    {apex_x_i, apex_y_i, apex_z_i} = '0;
    {end_b_x_i, end_b_y_i, end_b_z_i} = '0;
    exp_wr = '0;
    exp_rd = '0;
    error_count = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    idle_mode = IDLE_NONE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(IDLE_NONE, 200);
    test_random_phase(IDLE_SEND, 250);
    test_random_phase(IDLE_RECV, 250);
    test_random_phase(IDLE_BOTH, 250);
    test_back_pressure();
    test_drain_pause();
    test_random_phase(IDLE_NONE, 200);

    drain_results();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (error_count == 0 && exp_wr == exp_rd) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
